// File: rtl/cpf_pkg.sv
// shared types, constants and the crc byte update for the packet framer
package cpf_pkg;

  localparam int BYTE_W = 8;
  localparam int DEFAULT_PAYLOAD_BYTES = 21;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] HEADER_RST = 8'h12;
  localparam logic [BYTE_W-1:0] TYPE_RST   = 8'h01;
  localparam logic [BYTE_W-1:0] TAIL_RST   = 8'h13;
  localparam logic [BYTE_W-1:0] POLY_RST   = 8'hD5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER = 2'd0,
    REG_TYPE   = 2'd1,
    REG_TAIL   = 2'd2,
    REG_POLY   = 2'd3
  } cfg_reg_t;

  // which byte of the held item goes out next
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TYPE,
    PH_DATA,
    PH_CRC,
    PH_TAIL
  } phase_t;

  // reflected crc-8, one byte lsb first
  function automatic logic [BYTE_W-1:0] crc_feed(
    input logic [BYTE_W-1:0] crc_in,
    input logic [BYTE_W-1:0] val_in,
    input logic [BYTE_W-1:0] poly
  );
    logic [BYTE_W-1:0] crc;
    logic [BYTE_W-1:0] val;
    logic              mix;
    crc = crc_in;
    val = val_in;
    for (int k = 0; k < BYTE_W; k++) begin
      mix = crc[0] ^ val[0];
      crc = {1'b0, crc[BYTE_W-1:1]};
      if (mix) begin
        crc = crc ^ poly;
      end
      val = {1'b0, val[BYTE_W-1:1]};
    end
    return crc;
  endfunction

endpackage

// File: rtl/cpf_in_if.sv
// input channel: payload bytes with valid/ready
interface cpf_in_if;
  logic                       valid;
  logic                       ready;
  logic [cpf_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// File: rtl/cpf_out_if.sv
// result channel: framed bytes with valid/ready
interface cpf_out_if;
  logic                       valid;
  logic                       ready;
  logic [cpf_pkg::BYTE_W-1:0] out_byte;
  logic                       run_last;
  logic                       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end,
                  output ready);
endinterface

// File: rtl/crc8_packet_framer_unit.sv
// framer top level: wraps payload bytes into header/type/payload/crc/tail frames
//
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   data_byte[7:0]
//  out_ch    out  valid/ready   out_byte[7:0], run_last, frame_end
//  cfg_*     in   cfg_we        cfg_index[1:0], cfg_data[7:0]
//
// middle payload bytes stream at one per cycle while the output is not stalled;
// the first and last payload byte of a frame each give three bytes (header,
// type, payload; payload, crc, tail), so N payload bytes give N+4 output bytes
// item register and output register each hold one item; while a result waits,
// input is taken only into an empty item register; synchronous active-low reset, no clearing pass
module crc8_packet_framer_unit #(
  parameter int PAYLOAD_BYTES = cpf_pkg::DEFAULT_PAYLOAD_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  cpf_in_if.sink                       in_ch,
  cpf_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [cpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpf_pkg::BYTE_W-1:0]   cfg_data
);

  localparam int LEN   = (PAYLOAD_BYTES < 2) ? 2 : PAYLOAD_BYTES;
  localparam int POS_W = $clog2(LEN);
  localparam logic [POS_W:0]   LEN_C  = (POS_W+1)'(LEN);
  localparam logic [POS_W-1:0] LAST_C = POS_W'(LEN - 1);

  // configuration
  logic [cpf_pkg::BYTE_W-1:0] header_r, type_r, tail_r, poly_r, type_crc_r;

  // frame state
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [cpf_pkg::BYTE_W-1:0] crc_r, crc_nxt;

  // item register
  logic                       a_valid_r, a_valid_nxt;
  logic [cpf_pkg::BYTE_W-1:0] a_data_r, a_crc_r;
  logic                       a_last_r;
  cpf_pkg::phase_t            phase_r, phase_nxt;

  // output register
  logic                       out_valid_r;
  logic [cpf_pkg::BYTE_W-1:0] out_byte_r;
  logic                       out_last_r, out_end_r;

  logic                       accept, load_b, a_done;
  logic [POS_W-1:0]           pos_eff;
  logic                       is_first, is_last;
  logic [cpf_pkg::BYTE_W-1:0] crc_base, crc_new;
  logic [cpf_pkg::BYTE_W-1:0] res_byte;
  logic                       res_last, res_end;

  // configuration writes; the crc of the type byte is kept ready for frame starts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r   <= cpf_pkg::HEADER_RST;
      type_r     <= cpf_pkg::TYPE_RST;
      tail_r     <= cpf_pkg::TAIL_RST;
      poly_r     <= cpf_pkg::POLY_RST;
      type_crc_r <= cpf_pkg::crc_feed('0, cpf_pkg::TYPE_RST, cpf_pkg::POLY_RST);
    end else if (cfg_we) begin
      unique case (cpf_pkg::cfg_reg_t'(cfg_index))
        cpf_pkg::REG_HEADER: header_r <= cfg_data;
        cpf_pkg::REG_TYPE: begin
          type_r     <= cfg_data;
          type_crc_r <= cpf_pkg::crc_feed('0, cfg_data, poly_r);
        end
        cpf_pkg::REG_TAIL: tail_r <= cfg_data;
        cpf_pkg::REG_POLY: begin
          poly_r     <= cfg_data;
          type_crc_r <= cpf_pkg::crc_feed('0, type_r, cfg_data);
        end
        default: ;
      endcase
    end
  end

  // handshakes
  assign load_b       = a_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !a_valid_r || a_done;
  assign accept       = in_ch.valid && in_ch.ready;

  // frame position and crc of the incoming byte
  always_comb begin
    pos_eff  = ({1'b0, pos_r} >= LEN_C) ? '0 : pos_r;
    is_first = (pos_eff == '0);
    is_last  = (pos_eff == LAST_C);
    crc_base = is_first ? type_crc_r : crc_r;
    crc_new  = cpf_pkg::crc_feed(crc_base, in_ch.data_byte, poly_r);
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    if (accept) begin
      pos_nxt = is_last ? '0 : pos_eff + POS_W'(1);
      crc_nxt = is_last ? '0 : crc_new;
    end
  end

  // next phase of the held item
  always_comb begin
    phase_nxt   = phase_r;
    a_valid_nxt = a_valid_r;
    if (load_b) begin
      unique case (phase_r)
        cpf_pkg::PH_HEADER: phase_nxt = cpf_pkg::PH_TYPE;
        cpf_pkg::PH_TYPE:   phase_nxt = cpf_pkg::PH_DATA;
        cpf_pkg::PH_DATA:   phase_nxt = cpf_pkg::PH_CRC;
        cpf_pkg::PH_CRC:    phase_nxt = cpf_pkg::PH_TAIL;
        cpf_pkg::PH_TAIL:   phase_nxt = cpf_pkg::PH_HEADER;
        default:            phase_nxt = cpf_pkg::PH_HEADER;
      endcase
      if (a_done) begin
        a_valid_nxt = 1'b0;
      end
    end
    if (accept) begin
      phase_nxt   = is_first ? cpf_pkg::PH_HEADER : cpf_pkg::PH_DATA;
      a_valid_nxt = 1'b1;
    end
  end

  // byte selected for the current phase
  always_comb begin
    res_byte = a_data_r;
    res_last = 1'b0;
    res_end  = 1'b0;
    unique case (phase_r)
      cpf_pkg::PH_HEADER: res_byte = header_r;
      cpf_pkg::PH_TYPE:   res_byte = type_r;
      cpf_pkg::PH_DATA: begin
        res_byte = a_data_r;
        res_last = !a_last_r;
      end
      cpf_pkg::PH_CRC:    res_byte = a_crc_r;
      cpf_pkg::PH_TAIL: begin
        res_byte = tail_r;
        res_last = 1'b1;
        res_end  = 1'b1;
      end
      default: ;
    endcase
    a_done = load_b && res_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= '0;
      a_valid_r   <= 1'b0;
      phase_r     <= cpf_pkg::PH_HEADER;
      out_valid_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      a_valid_r <= a_valid_nxt;
      phase_r   <= phase_nxt;
      if (load_b) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_data_r <= in_ch.data_byte;
      a_crc_r  <= crc_new;
      a_last_r <= is_last;
    end
    if (load_b) begin
      out_byte_r <= res_byte;
      out_last_r <= res_last;
      out_end_r  <= res_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.run_last  = out_last_r;
  assign out_ch.frame_end = out_end_r;

  // position never leaves the frame
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_r} < LEN_C)
    else $error("frame position out of range");

  // closing a frame clears the running crc and position
  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_last |=> (crc_r == '0) && (pos_r == '0))
    else $error("frame state not cleared after last byte");

  // a frame start item begins with its header
  a_start_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_first |=> a_valid_r && (phase_r == cpf_pkg::PH_HEADER))
    else $error("frame start item does not begin with header");

  // type byte is always followed by the payload byte
  a_type_data: assert property (@(posedge clk) disable iff (!rst_n)
    load_b && (phase_r == cpf_pkg::PH_TYPE) |=> phase_r == cpf_pkg::PH_DATA)
    else $error("type byte not followed by payload byte");

  // the tail byte always closes the item
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_r |-> out_last_r)
    else $error("tail byte not marked as last of item");

endmodule
